// ----- src/lci_pkg.sv -----
// Package for the line/circle intersection pipeline.
// Holds the widths, result codes and the structs shared between the modules.
// No dependencies.
`default_nettype none

package lci_pkg;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int BW = PW + 1;
    localparam int SQW = 2 * PW;
    localparam int DPW = 4 * CW;
    localparam int XW = DPW + 2 * FB;
    localparam int RTW = XW / 2;
    localparam int RMW = RTW + 2;
    localparam int NW = BW + FB;
    localparam int TW = NW + 1;
    localparam int QW = CW + 1;
    localparam int CKW = PW + QW;
    localparam int DIV_LAT = QW + 3;

    localparam logic [1:0] HIT_NONE = 2'd0;
    localparam logic [1:0] HIT_ONE = 2'd1;
    localparam logic [1:0] HIT_TWO = 2'd2;

    typedef struct packed {
        logic a_zero;
        logic d_neg;
        logic d_zero;
        logic [CW-1:0] dflt;
    } side_t;

    typedef struct packed {
        logic sat;
        logic [CW-1:0] value;
    } param_t;

endpackage

`default_nettype wire

// ----- src/line_circle_intersection.sv -----
// Top level of the line/circle intersection pipeline.
// Instantiates lci_front, lci_sqrt and two lci_div; uses lci_pkg.
//
//   channel  | handshake          | word
//   ---------+--------------------+----------------------------------------------
//   s_       | s_valid / s_ready  | centre, radius, start, end, default_param
//   m_       | m_valid / m_ready  | hit_count, first_param, second_param, saturated
//
// A word can enter every cycle while m_ is not stalled; each word passes through
// the 80-stage square root and the 36-stage dividers on its way to the output.
// Reset is synchronous on aresetn and clears only the valid bits.
// A result held on m_ without m_ready freezes the whole pipeline; s_ready
// is high whenever the output register is empty or being taken.
`default_nettype none

module line_circle_intersection (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [lci_pkg::CW-1:0]   s_center_x,
    input  logic signed [lci_pkg::CW-1:0]   s_center_y,
    input  logic        [lci_pkg::CW-2:0]   s_circle_radius,
    input  logic signed [lci_pkg::CW-1:0]   s_start_x,
    input  logic signed [lci_pkg::CW-1:0]   s_start_y,
    input  logic signed [lci_pkg::CW-1:0]   s_end_x,
    input  logic signed [lci_pkg::CW-1:0]   s_end_y,
    input  logic signed [lci_pkg::CW-1:0]   s_default_param,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic        [1:0]               m_hit_count,
    output logic signed [lci_pkg::CW-1:0]   m_first_param,
    output logic signed [lci_pkg::CW-1:0]   m_second_param,
    output logic                            m_saturated
);
    import lci_pkg::*;

    logic en;

    logic fr_valid;
    logic [PW-1:0] fr_a;
    logic signed [BW-1:0] fr_b;
    logic [DPW-1:0] fr_dpos;
    side_t fr_side;

    logic sq_valid, sq_exact;
    logic [RTW-1:0] sq_root;
    logic [PW-1:0] sq_a;
    logic signed [BW-1:0] sq_b;
    side_t sq_side;

    logic signed [TW-1:0] n_w;
    logic tv_reg;
    logic signed [TW-1:0] t1_reg, t2_reg;
    logic [PW-1:0] ta_reg;
    side_t ts_reg;
    side_t sd_reg [DIV_LAT];

    logic dp_valid, dm_valid;
    param_t dp_res, dm_res;
    side_t side_f;

    logic m_valid_reg, sat_reg;
    logic [1:0] hit_reg;
    logic [CW-1:0] first_reg, second_reg;

    assign en = m_ready | ~m_valid_reg;
    assign s_ready = en;

    lci_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (s_valid),
        .center_x     (s_center_x),
        .center_y     (s_center_y),
        .circle_radius(s_circle_radius),
        .start_x      (s_start_x),
        .start_y      (s_start_y),
        .end_x        (s_end_x),
        .end_y        (s_end_y),
        .default_param(s_default_param),
        .out_valid    (fr_valid),
        .out_a        (fr_a),
        .out_b        (fr_b),
        .out_dpos     (fr_dpos),
        .out_side     (fr_side)
    );

    lci_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (fr_valid),
        .in_dpos  (fr_dpos),
        .in_a     (fr_a),
        .in_b     (fr_b),
        .in_side  (fr_side),
        .out_valid(sq_valid),
        .out_root (sq_root),
        .out_exact(sq_exact),
        .out_a    (sq_a),
        .out_b    (sq_b),
        .out_side (sq_side)
    );

    assign n_w = -(TW'(sq_b) <<< FB);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tv_reg <= 1'b0;
        end else if (en) begin
            tv_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg <= n_w + $signed(TW'(sq_root));
            t2_reg <= n_w - $signed(TW'(sq_root)) - $signed(TW'(!sq_exact));
            ta_reg <= sq_a;
            ts_reg <= sq_side;
            sd_reg[0] <= ts_reg;
            for (int k = 1; k < DIV_LAT; k++) begin
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    lci_div u_div_plus (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (tv_reg),
        .in_num   (t1_reg),
        .in_den   (ta_reg),
        .out_valid(dp_valid),
        .out_res  (dp_res)
    );

    lci_div u_div_minus (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (tv_reg),
        .in_num   (t2_reg),
        .in_den   (ta_reg),
        .out_valid(dm_valid),
        .out_res  (dm_res)
    );

    assign side_f = sd_reg[DIV_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dp_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (side_f.a_zero || side_f.d_neg) begin
                hit_reg <= HIT_NONE;
                first_reg <= side_f.dflt;
                second_reg <= side_f.dflt;
                sat_reg <= 1'b0;
            end else if (side_f.d_zero) begin
                hit_reg <= HIT_ONE;
                first_reg <= dp_res.value;
                second_reg <= side_f.dflt;
                sat_reg <= dp_res.sat;
            end else begin
                hit_reg <= HIT_TWO;
                first_reg <= dp_res.value;
                second_reg <= dm_res.value;
                sat_reg <= dp_res.sat | dm_res.sat;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_hit_count = hit_reg;
    assign m_first_param = first_reg;
    assign m_second_param = second_reg;
    assign m_saturated = sat_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid set right after reset");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> m_hit_count != HIT_NONE)
        else $error("saturation reported without an intersection");
    assert property (@(posedge aclk) disable iff (!aresetn)
        fr_valid |-> !(fr_side.d_zero && fr_side.d_neg))
        else $error("discriminant both zero and negative");
    assert property (@(posedge aclk) disable iff (!aresetn)
        dp_valid == dm_valid)
        else $error("dividers out of step");
`endif

endmodule

`default_nettype wire

// ----- src/lci_front.sv -----
// Front end: differences, products, the quadratic terms and the discriminant.
// Eight register stages; uses lci_pkg.
`default_nettype none

module lci_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [lci_pkg::CW-1:0]   center_x,
    input  logic signed [lci_pkg::CW-1:0]   center_y,
    input  logic        [lci_pkg::CW-2:0]   circle_radius,
    input  logic signed [lci_pkg::CW-1:0]   start_x,
    input  logic signed [lci_pkg::CW-1:0]   start_y,
    input  logic signed [lci_pkg::CW-1:0]   end_x,
    input  logic signed [lci_pkg::CW-1:0]   end_y,
    input  logic signed [lci_pkg::CW-1:0]   default_param,
    output logic                            out_valid,
    output logic        [lci_pkg::PW-1:0]   out_a,
    output logic signed [lci_pkg::BW-1:0]   out_b,
    output logic        [lci_pkg::DPW-1:0]  out_dpos,
    output lci_pkg::side_t                  out_side
);
    import lci_pkg::*;

    localparam int NS = 8;

    logic [NS-1:0] vld_reg;
    logic [CW-1:0] dflt_reg [NS];

    logic signed [DW-1:0] dx_reg, dy_reg, ex_reg, ey_reg;
    logic [CW-2:0] rr_reg;
    logic signed [PW-1:0] pxx_reg, pyy_reg, pxe_reg, pye_reg, pex_reg, pey_reg;
    logic [PW-1:0] prr_reg;
    logic [PW-1:0] a3_reg;
    logic signed [BW-1:0] b3_reg, c3_reg;
    logic [PW-1:0] a4_reg, bmag_reg, cmag_reg;
    logic signed [BW-1:0] b4_reg;
    logic cneg4_reg, az4_reg;
    logic [PW-1:0] a5_reg;
    logic signed [BW-1:0] b5_reg;
    logic cneg5_reg, az5_reg;
    logic [PW-1:0] bb_ll_reg, bb_lh_reg, bb_hh_reg;
    logic [PW-1:0] ac_ll_reg, ac_lh_reg, ac_hl_reg, ac_hh_reg;
    logic [PW-1:0] a6_reg;
    logic signed [BW-1:0] b6_reg;
    logic cneg6_reg, az6_reg;
    logic [SQW-1:0] bsq_reg, acp_reg;
    logic [PW-1:0] a7_reg;
    logic signed [BW-1:0] b7_reg;
    logic az7_reg;
    logic signed [SQW:0] d_reg;
    logic [PW-1:0] a8_reg;
    logic signed [BW-1:0] b8_reg;
    logic az8_reg, dneg_reg, dzero_reg;
    logic [DPW-1:0] dpos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dflt_reg[0] <= default_param;
            for (int k = 1; k < NS; k++) begin
                dflt_reg[k] <= dflt_reg[k-1];
            end

            dx_reg <= DW'(end_x) - DW'(start_x);
            dy_reg <= DW'(end_y) - DW'(start_y);
            ex_reg <= DW'(start_x) - DW'(center_x);
            ey_reg <= DW'(start_y) - DW'(center_y);
            rr_reg <= circle_radius;

            pxx_reg <= dx_reg * dx_reg;
            pyy_reg <= dy_reg * dy_reg;
            pxe_reg <= dx_reg * ex_reg;
            pye_reg <= dy_reg * ey_reg;
            pex_reg <= ex_reg * ex_reg;
            pey_reg <= ey_reg * ey_reg;
            prr_reg <= PW'(rr_reg) * PW'(rr_reg);

            a3_reg <= PW'(pxx_reg) + PW'(pyy_reg);
            b3_reg <= BW'(pxe_reg) + BW'(pye_reg);
            c3_reg <= BW'(pex_reg) + BW'(pey_reg) - $signed(BW'(prr_reg));

            a4_reg <= a3_reg;
            b4_reg <= b3_reg;
            az4_reg <= (a3_reg == '0);
            bmag_reg <= PW'(b3_reg[BW-1] ? -b3_reg : b3_reg);
            cmag_reg <= PW'(c3_reg[BW-1] ? -c3_reg : c3_reg);
            cneg4_reg <= c3_reg[BW-1];

            a5_reg <= a4_reg;
            b5_reg <= b4_reg;
            az5_reg <= az4_reg;
            cneg5_reg <= cneg4_reg;
            bb_ll_reg <= PW'(bmag_reg[DW-1:0]) * PW'(bmag_reg[DW-1:0]);
            bb_lh_reg <= PW'(bmag_reg[DW-1:0]) * PW'(bmag_reg[PW-1:DW]);
            bb_hh_reg <= PW'(bmag_reg[PW-1:DW]) * PW'(bmag_reg[PW-1:DW]);
            ac_ll_reg <= PW'(a4_reg[DW-1:0]) * PW'(cmag_reg[DW-1:0]);
            ac_lh_reg <= PW'(a4_reg[DW-1:0]) * PW'(cmag_reg[PW-1:DW]);
            ac_hl_reg <= PW'(a4_reg[PW-1:DW]) * PW'(cmag_reg[DW-1:0]);
            ac_hh_reg <= PW'(a4_reg[PW-1:DW]) * PW'(cmag_reg[PW-1:DW]);

            a6_reg <= a5_reg;
            b6_reg <= b5_reg;
            az6_reg <= az5_reg;
            cneg6_reg <= cneg5_reg;
            bsq_reg <= {bb_hh_reg, bb_ll_reg} + (SQW'(bb_lh_reg) << (DW + 1));
            acp_reg <= {ac_hh_reg, ac_ll_reg}
                       + ((SQW'(ac_lh_reg) + SQW'(ac_hl_reg)) << DW);

            a7_reg <= a6_reg;
            b7_reg <= b6_reg;
            az7_reg <= az6_reg;
            d_reg <= cneg6_reg ? $signed({1'b0, bsq_reg}) + $signed({1'b0, acp_reg})
                               : $signed({1'b0, bsq_reg}) - $signed({1'b0, acp_reg});

            a8_reg <= a7_reg;
            b8_reg <= b7_reg;
            az8_reg <= az7_reg;
            dneg_reg <= d_reg[SQW];
            dzero_reg <= (d_reg == '0);
            dpos_reg <= d_reg[SQW] ? '0 : d_reg[DPW-1:0];
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_a = a8_reg;
    assign out_b = b8_reg;
    assign out_dpos = dpos_reg;
    assign out_side.a_zero = az8_reg;
    assign out_side.d_neg = dneg_reg;
    assign out_side.d_zero = dzero_reg;
    assign out_side.dflt = dflt_reg[NS-1];

endmodule

`default_nettype wire

// ----- src/lci_sqrt.sv -----
// Pipelined integer square root of the discriminant scaled by 2^(2*FB).
// One result bit per stage; uses lci_pkg.
`default_nettype none

module lci_sqrt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic        [lci_pkg::DPW-1:0]  in_dpos,
    input  logic        [lci_pkg::PW-1:0]   in_a,
    input  logic signed [lci_pkg::BW-1:0]   in_b,
    input  lci_pkg::side_t                  in_side,
    output logic                            out_valid,
    output logic        [lci_pkg::RTW-1:0]  out_root,
    output logic                            out_exact,
    output logic        [lci_pkg::PW-1:0]   out_a,
    output logic signed [lci_pkg::BW-1:0]   out_b,
    output lci_pkg::side_t                  out_side
);
    import lci_pkg::*;

    logic [RTW-1:0] vld_reg;
    logic [RMW-1:0] rem_reg [RTW];
    logic [RTW-1:0] root_reg [RTW];
    logic [DPW-1:0] dpos_reg [RTW];
    logic [PW-1:0] a_reg [RTW];
    logic signed [BW-1:0] b_reg [RTW];
    side_t side_reg [RTW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[RTW-2:0], in_valid};
        end
    end

    genvar i;
    for (i = 0; i < RTW; i++) begin : g_step
        localparam int K = RTW - 1 - i;
        logic [RMW-1:0] rem_in;
        logic [RTW-1:0] root_in;
        logic [DPW-1:0] dpos_in;
        logic [PW-1:0] a_in;
        logic signed [BW-1:0] b_in;
        side_t side_in;
        logic [1:0] pair;
        logic [RMW:0] rem_sh, trial, rem_next;
        logic [RTW-1:0] root_next;
        logic ge;

        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign root_in = '0;
            assign dpos_in = in_dpos;
            assign a_in = in_a;
            assign b_in = in_b;
            assign side_in = in_side;
        end else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign dpos_in = dpos_reg[i-1];
            assign a_in = a_reg[i-1];
            assign b_in = b_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        if (2 * K >= 2 * FB) begin : g_data
            assign pair = dpos_in[2*K-2*FB +: 2];
        end else begin : g_zero
            assign pair = 2'b00;
        end

        assign rem_sh = {rem_in[RMW-2:0], pair};
        assign trial = (RMW+1)'({root_in, 2'b01});
        assign ge = (rem_sh >= trial);
        assign rem_next = ge ? rem_sh - trial : rem_sh;
        assign root_next = {root_in[RTW-2:0], ge};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= rem_next[RMW-1:0];
                root_reg[i] <= root_next;
                dpos_reg[i] <= dpos_in;
                a_reg[i] <= a_in;
                b_reg[i] <= b_in;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[RTW-1];
    assign out_root = root_reg[RTW-1];
    assign out_exact = (rem_reg[RTW-1] == '0);
    assign out_a = a_reg[RTW-1];
    assign out_b = b_reg[RTW-1];
    assign out_side = side_reg[RTW-1];

endmodule

`default_nettype wire

// ----- src/lci_div.sv -----
// Pipelined floor division of a signed numerator by a positive denominator,
// one quotient bit per stage, with clamping to the output range; uses lci_pkg.
`default_nettype none

module lci_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [lci_pkg::TW-1:0]   in_num,
    input  logic        [lci_pkg::PW-1:0]   in_den,
    output logic                            out_valid,
    output lci_pkg::param_t                 out_res
);
    import lci_pkg::*;

    localparam logic [QW-1:0] LIM_Q = QW'(1) << (CW - 1);
    localparam logic [QW:0] LIM_M = (QW+1)'(1) << (CW - 1);

    logic [DIV_LAT-1:0] vld_reg;
    logic [TW-1:0] mag_reg;
    logic mneg_reg;
    logic [PW-1:0] mden_reg;
    logic [PW-1:0] crem_reg, cden_reg;
    logic [QW-1:0] clow_reg;
    logic cneg_reg, covf_reg;
    logic [PW-1:0] rem_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [PW-1:0] den_reg [QW];
    logic neg_reg [QW];
    logic ovf_reg [QW];
    param_t res_reg;

    logic [QW-1:0] quo_f;
    logic [QW:0] mq;
    param_t res_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= TW'(in_num[TW-1] ? -in_num : in_num);
            mneg_reg <= in_num[TW-1];
            mden_reg <= in_den;

            covf_reg <= (CKW'(mag_reg) >= {mden_reg, {QW{1'b0}}});
            crem_reg <= PW'(mag_reg[TW-1:QW]);
            clow_reg <= mag_reg[QW-1:0];
            cden_reg <= mden_reg;
            cneg_reg <= mneg_reg;
        end
    end

    genvar j;
    for (j = 0; j < QW; j++) begin : g_step
        logic [PW-1:0] rem_in, den_in;
        logic [QW-1:0] quo_in, low_in;
        logic neg_in, ovf_in, ge;
        logic [PW:0] rem_sh, rem_next;

        if (j == 0) begin : g_first
            assign rem_in = crem_reg;
            assign den_in = cden_reg;
            assign quo_in = '0;
            assign low_in = clow_reg;
            assign neg_in = cneg_reg;
            assign ovf_in = covf_reg;
        end else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign low_in = low_reg[j-1];
            assign neg_in = neg_reg[j-1];
            assign ovf_in = ovf_reg[j-1];
        end

        assign rem_sh = {rem_in, low_in[QW-1-j]};
        assign ge = (rem_sh >= {1'b0, den_in});
        assign rem_next = ge ? rem_sh - {1'b0, den_in} : rem_sh;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= rem_next[PW-1:0];
                quo_reg[j] <= {quo_in[QW-2:0], ge};
                low_reg[j] <= low_in;
                den_reg[j] <= den_in;
                neg_reg[j] <= neg_in;
                ovf_reg[j] <= ovf_in;
            end
        end
    end

    always_comb begin
        quo_f = quo_reg[QW-1];
        mq = (QW+1)'(quo_f) + (QW+1)'(rem_reg[QW-1] != '0);
        res_next.sat = 1'b0;
        res_next.value = CW'(quo_f);
        if (neg_reg[QW-1]) begin
            if (ovf_reg[QW-1] || mq > LIM_M) begin
                res_next.sat = 1'b1;
                res_next.value = {1'b1, {(CW-1){1'b0}}};
            end else begin
                res_next.value = CW'((QW+1)'(0) - mq);
            end
        end else if (ovf_reg[QW-1] || quo_f >= LIM_Q) begin
            res_next.sat = 1'b1;
            res_next.value = {1'b0, {(CW-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = vld_reg[DIV_LAT-1];
    assign out_res = res_reg;

endmodule

`default_nettype wire
